// ===== sv/lidar_scan_polar_rasterizer_unit_assert.svh =====
// Assertion macros for the lidar rasterizer projection engine.
`ifndef LIDAR_SCAN_POLAR_RASTERIZER_UNIT_ASSERT_SVH
`define LIDAR_SCAN_POLAR_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define LSPR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define LSPR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lspr_pkg.sv =====
// Shared types, constants and the arctangent table of the lidar rasterizer.
`timescale 1ns / 1ps

package lspr_pkg;

    localparam int IMAGE_SIZE    = 500;
    localparam int MAX_SAMPLES   = 4096;
    localparam int IDX_W         = 12;
    localparam int ANGLE_W       = 16;
    localparam int RANGE_W       = 16;
    localparam int PPM_W         = 10;
    localparam int PIX_W         = 9;

    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_IDX_W  = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W      = 33;
    localparam int CORDIC_X0     = 652032874;
    localparam int FRAC_BITS     = 38;
    localparam int MAG_W         = 31;
    localparam int RP_W          = RANGE_W + PPM_W;
    localparam int PROD_W        = RP_W + MAG_W;
    localparam int SUM_W         = PROD_W + 2;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'h8000;
    localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 16'd182;
    localparam logic [PPM_W-1:0]   PPM_RST         = 10'd100;
    localparam logic [PIX_W-1:0]   CENTER_RST      = 9'd250;

    typedef enum logic [1:0] {
        REG_START_ANGLE = 2'd0,
        REG_ANGLE_STEP  = 2'd1,
        REG_PPM         = 2'd2,
        REG_CENTER      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] angle_step;
        logic [PPM_W-1:0]   pixels_per_meter;
        logic [PIX_W-1:0]   center_pixel;
    } cfg_t;

    // One classified sample waiting for the projection engine.
    typedef struct packed {
        logic [RANGE_W-1:0] range_value;
        logic               range_valid;
        logic [IDX_W-1:0]   beam_index;
        logic [ANGLE_W-1:0] angle;
    } q_item_t;

    // atan(2^-i) in units of 2^32 per full turn.
    function automatic logic [31:0] atan_bam(input logic [CORDIC_IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            4'd0:    v = 32'd536870912;
            4'd1:    v = 32'd316933406;
            4'd2:    v = 32'd167458907;
            4'd3:    v = 32'd85004756;
            4'd4:    v = 32'd42667331;
            4'd5:    v = 32'd21354465;
            4'd6:    v = 32'd10680862;
            4'd7:    v = 32'd5340245;
            4'd8:    v = 32'd2670163;
            4'd9:    v = 32'd1335087;
            4'd10:   v = 32'd667544;
            4'd11:   v = 32'd333772;
            4'd12:   v = 32'd166886;
            4'd13:   v = 32'd83443;
            4'd14:   v = 32'd41722;
            4'd15:   v = 32'd20861;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/lspr_front.sv =====
// Front end: accept samples, assign beam index and beam angle.
`timescale 1ns / 1ps

module lspr_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lspr_pkg::cfg_t               cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lspr_pkg::RANGE_W-1:0] s_range_value,
    input  logic                         s_range_valid,
    input  logic                         s_scan_start,
    input  logic                         q_full,
    output logic                         q_push,
    output lspr_pkg::q_item_t            q_item
);

    localparam logic [lspr_pkg::IDX_W-1:0] IDX_LAST = lspr_pkg::IDX_W'(lspr_pkg::MAX_SAMPLES - 1);
    localparam int MUL_W = lspr_pkg::IDX_W + lspr_pkg::ANGLE_W;

    logic [lspr_pkg::IDX_W-1:0]   counter_reg;
    logic [lspr_pkg::IDX_W-1:0]   counter_next;
    logic [lspr_pkg::IDX_W-1:0]   idx_w;
    logic [MUL_W-1:0]             turn_w;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Scan start forces index zero; counter resumes after it.
    assign idx_w  = s_scan_start ? '0 : counter_reg;
    // Only the low bits of index*step matter: angle wraps per turn.
    assign turn_w = MUL_W'(idx_w) * MUL_W'(cfg.angle_step);

    always_comb begin
        q_item.range_value = s_range_value;
        q_item.range_valid = s_range_valid;
        q_item.beam_index  = idx_w;
        q_item.angle       = cfg.start_angle + turn_w[lspr_pkg::ANGLE_W-1:0];
    end

    always_comb begin
        counter_next = counter_reg;
        if (q_push) begin
            counter_next = (idx_w == IDX_LAST) ? '0 : idx_w + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
        end else begin
            counter_reg <= counter_next;
        end
    end

endmodule

// ===== sv/lspr_queue.sv =====
// Short item queue between the front end and the projection engine.
`timescale 1ns / 1ps

module lspr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lspr_pkg::q_item_t   push_item,
    output logic                full,
    input  logic                pop,
    output lspr_pkg::q_item_t   head_item,
    output logic                not_empty
);

    localparam int CNT_W = lspr_pkg::QUEUE_PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(lspr_pkg::QUEUE_DEPTH);

    lspr_pkg::q_item_t mem_reg [lspr_pkg::QUEUE_DEPTH];
    logic [lspr_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [lspr_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]                 count_reg;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sv/lspr_back.sv =====
// Projection engine: iterative CORDIC, shared multiplier, pixel clip, result register.
`timescale 1ns / 1ps

`include "lidar_scan_polar_rasterizer_unit_assert.svh"

module lspr_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lspr_pkg::cfg_t               cfg,
    input  logic                         q_valid,
    input  lspr_pkg::q_item_t            q_item,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lspr_pkg::PIX_W-1:0]   m_pixel_x,
    output logic [lspr_pkg::PIX_W-1:0]   m_pixel_y,
    output logic                         m_hit,
    output logic [lspr_pkg::IDX_W-1:0]   m_beam_index
);

    localparam int CW = lspr_pkg::CORDIC_W;
    localparam int SW = lspr_pkg::SUM_W;
    localparam int QW = SW - lspr_pkg::FRAC_BITS;
    localparam logic [lspr_pkg::CORDIC_IDX_W-1:0] ITER_LAST =
        lspr_pkg::CORDIC_IDX_W'(lspr_pkg::CORDIC_STEPS - 1);
    localparam logic [QW-1:0] IMG_LIMIT = QW'(lspr_pkg::IMAGE_SIZE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_ADD,
        ST_CLS,
        ST_DONE
    } state_t;

    state_t                               state_reg, state_next;
    logic [lspr_pkg::CORDIC_IDX_W-1:0]    iter_reg, iter_next;
    logic                                 axis_reg, axis_next;
    logic                                 m_valid_reg, m_valid_next;

    logic signed [CW-1:0]                 x_reg, x_next;
    logic signed [CW-1:0]                 y_reg, y_next;
    logic signed [CW-1:0]                 z_reg, z_next;
    logic                                 flip_reg, flip_next;
    logic [lspr_pkg::RANGE_W-1:0]         range_reg, range_next;
    logic                                 valid_reg, valid_next;
    logic [lspr_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic [lspr_pkg::RP_W-1:0]            rp_reg, rp_next;
    logic [lspr_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic                                 neg_reg, neg_next;
    logic signed [SW-1:0]                 sum_reg, sum_next;
    logic [lspr_pkg::PIX_W-1:0]           px_reg, px_next;
    logic [lspr_pkg::PIX_W-1:0]           py_reg, py_next;
    logic                                 hx_reg, hx_next;
    logic                                 hy_reg, hy_next;
    logic [lspr_pkg::PIX_W-1:0]           out_x_reg, out_x_next;
    logic [lspr_pkg::PIX_W-1:0]           out_y_reg, out_y_next;
    logic                                 out_hit_reg, out_hit_next;
    logic [lspr_pkg::IDX_W-1:0]           out_idx_reg, out_idx_next;

    logic                                 flip_w;
    logic [lspr_pkg::ANGLE_W-1:0]         ang_adj_w;
    logic signed [CW-1:0]                 dx_w, dy_w, at_w;
    logic signed [CW-1:0]                 trig_w;
    logic [lspr_pkg::MAG_W-1:0]           mag_w;
    logic signed [SW-1:0]                 cen_w, prod_ext_w;
    logic [QW-1:0]                        q_w;
    logic                                 ax_hit_w;
    logic [lspr_pkg::PIX_W-1:0]           ax_pix_w;
    logic                                 item_hit_w;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // Angles in the left half plane turn by half a turn; negate results at the end.
    assign flip_w    = q_item.angle[15] ^ q_item.angle[14];
    assign ang_adj_w = {q_item.angle[15] ^ flip_w, q_item.angle[14:0]};

    assign dx_w = y_reg >>> iter_reg;
    assign dy_w = x_reg >>> iter_reg;
    assign at_w = signed'({1'b0, lspr_pkg::atan_bam(iter_reg)});

    assign trig_w = axis_reg ? y_reg : x_reg;
    assign mag_w  = trig_w[CW-1] ? lspr_pkg::MAG_W'(-trig_w) : lspr_pkg::MAG_W'(trig_w);

    assign cen_w      = signed'({{(SW - lspr_pkg::PIX_W - lspr_pkg::FRAC_BITS){1'b0}},
                                 cfg.center_pixel, {lspr_pkg::FRAC_BITS{1'b0}}});
    assign prod_ext_w = signed'(SW'(prod_reg));

    // Truncate toward zero: a negative sum above -1 maps to pixel zero.
    assign q_w = sum_reg[SW-1:lspr_pkg::FRAC_BITS];
    always_comb begin
        if (sum_reg[SW-1]) begin
            ax_hit_w = (&q_w) && (|sum_reg[lspr_pkg::FRAC_BITS-1:0]);
            ax_pix_w = '0;
        end else begin
            ax_hit_w = (q_w < IMG_LIMIT);
            ax_pix_w = q_w[lspr_pkg::PIX_W-1:0];
        end
    end

    assign item_hit_w = valid_reg && hx_reg && hy_reg;

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        axis_next    = axis_reg;
        m_valid_next = m_valid_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        flip_next    = flip_reg;
        range_next   = range_reg;
        valid_next   = valid_reg;
        idx_next     = idx_reg;
        rp_next      = rp_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        sum_next     = sum_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_hit_next = out_hit_reg;
        out_idx_next = out_idx_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    x_next     = CW'(lspr_pkg::CORDIC_X0);
                    y_next     = '0;
                    z_next     = signed'({ang_adj_w[15], ang_adj_w, 16'h0000});
                    flip_next  = flip_w;
                    range_next = q_item.range_value;
                    valid_next = q_item.range_valid;
                    idx_next   = q_item.beam_index;
                    iter_next  = '0;
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                if (!z_reg[CW-1]) begin
                    x_next = x_reg - dx_w;
                    y_next = y_reg + dy_w;
                    z_next = z_reg - at_w;
                end else begin
                    x_next = x_reg + dx_w;
                    y_next = y_reg - dy_w;
                    z_next = z_reg + at_w;
                end
                rp_next   = lspr_pkg::RP_W'(range_reg) * lspr_pkg::RP_W'(cfg.pixels_per_meter);
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST) begin
                    axis_next  = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = lspr_pkg::PROD_W'(rp_reg) * lspr_pkg::PROD_W'(mag_w);
                neg_next   = trig_w[CW-1] ^ flip_reg;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                sum_next   = neg_reg ? (cen_w - prod_ext_w) : (cen_w + prod_ext_w);
                state_next = ST_CLS;
            end
            ST_CLS: begin
                if (axis_reg) begin
                    py_next    = ax_pix_w;
                    hy_next    = ax_hit_w;
                    state_next = ST_DONE;
                end else begin
                    px_next    = ax_pix_w;
                    hx_next    = ax_hit_w;
                    axis_next  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_x_next   = item_hit_w ? px_reg : '0;
                    out_y_next   = item_hit_w ? py_reg : '0;
                    out_hit_next = item_hit_w;
                    out_idx_next = idx_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            flip_reg    <= flip_next;
            range_reg   <= range_next;
            valid_reg   <= valid_next;
            idx_reg     <= idx_next;
            rp_reg      <= rp_next;
            prod_reg    <= prod_next;
            neg_reg     <= neg_next;
            sum_reg     <= sum_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            hx_reg      <= hx_next;
            hy_reg      <= hy_next;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            out_hit_reg <= out_hit_next;
            out_idx_reg <= out_idx_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_x    = out_x_reg;
    assign m_pixel_y    = out_y_reg;
    assign m_hit        = out_hit_reg;
    assign m_beam_index = out_idx_reg;

    `LSPR_ASSERT_NXT(a_pop_starts_rot, q_pop, state_reg == ST_ROT && iter_reg == '0, "pop did not start rotation")
    `LSPR_ASSERT_NXT(a_rot_ends, state_reg == ST_ROT && iter_reg == ITER_LAST, state_reg == ST_MUL && !axis_reg, "rotation did not hand over to multiply")
    `LSPR_ASSERT_IMP(a_miss_zero, m_valid && !m_hit, m_pixel_x == '0 && m_pixel_y == '0, "miss item carries nonzero pixel")

endmodule

// ===== sv/lidar_scan_polar_rasterizer_unit.sv =====
// Top level of the lidar scan rasterizer: register port, front end, queue, projection engine.
`timescale 1ns / 1ps
// The engine pops a new item only when idle: the 16-step CORDIC loop, then per axis
//   multiply, add and clip on the one shared 26x31 multiplier and adder, then the result register.
// The queue takes two items while the engine is busy; s_ready drops only when it is full.
// Reset (aresetn low at a clock edge, synchronous) empties the queue, clears the index
//   counter and m_valid, and loads the register reset values.

module lidar_scan_polar_rasterizer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lspr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lspr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lspr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // Sample input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lspr_pkg::RANGE_W-1:0]     s_range_value,
    input  logic                             s_range_valid,
    input  logic                             s_scan_start,
    // Pixel output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lspr_pkg::PIX_W-1:0]       m_pixel_x,
    output logic [lspr_pkg::PIX_W-1:0]       m_pixel_y,
    output logic                             m_hit,
    output logic [lspr_pkg::IDX_W-1:0]       m_beam_index
);

    lspr_pkg::cfg_t     cfg_reg;
    lspr_pkg::cfg_t     cfg_next;
    lspr_pkg::reg_idx_t reg_sel_w;
    logic               wr_en_w;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_not_empty;
    lspr_pkg::q_item_t  q_in_item;
    lspr_pkg::q_item_t  q_head_item;

    // Registers sit on word addresses; byte offset bits do not select.
    assign reg_sel_w = lspr_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en_w   = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Write the selected register; keep only its low bits.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en_w) begin
            case (reg_sel_w)
                lspr_pkg::REG_START_ANGLE:
                    cfg_next.start_angle = pwdata[lspr_pkg::ANGLE_W-1:0];
                lspr_pkg::REG_ANGLE_STEP:
                    cfg_next.angle_step = pwdata[lspr_pkg::ANGLE_W-1:0];
                lspr_pkg::REG_PPM:
                    cfg_next.pixels_per_meter = pwdata[lspr_pkg::PPM_W-1:0];
                lspr_pkg::REG_CENTER:
                    cfg_next.center_pixel = pwdata[lspr_pkg::PIX_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_angle      <= lspr_pkg::START_ANGLE_RST;
            cfg_reg.angle_step       <= lspr_pkg::ANGLE_STEP_RST;
            cfg_reg.pixels_per_meter <= lspr_pkg::PPM_RST;
            cfg_reg.center_pixel     <= lspr_pkg::CENTER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back zero-extended register contents.
    always_comb begin
        case (reg_sel_w)
            lspr_pkg::REG_START_ANGLE:
                prdata = lspr_pkg::APB_DATA_W'(cfg_reg.start_angle);
            lspr_pkg::REG_ANGLE_STEP:
                prdata = lspr_pkg::APB_DATA_W'(cfg_reg.angle_step);
            lspr_pkg::REG_PPM:
                prdata = lspr_pkg::APB_DATA_W'(cfg_reg.pixels_per_meter);
            lspr_pkg::REG_CENTER:
                prdata = lspr_pkg::APB_DATA_W'(cfg_reg.center_pixel);
            default: prdata = '0;
        endcase
    end

    // Front end: index each sample and fix its beam angle at accept time.
    lspr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_range_value (s_range_value),
        .s_range_valid (s_range_valid),
        .s_scan_start  (s_scan_start),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in_item)
    );

    // Queue decouples sample intake from the slow projection engine.
    lspr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_head_item),
        .not_empty (q_not_empty)
    );

    // Back end: rotate, scale, offset, clip, and hold the result item.
    lspr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_not_empty),
        .q_item       (q_head_item),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_hit        (m_hit),
        .m_beam_index (m_beam_index)
    );

endmodule

// ===== tb/lspr_pixel_checker.sv =====
// Pixel checker for the lidar rasterizer: predicts every sample's pixel and compares the outputs.
`timescale 1ns / 1ps

module lspr_pixel_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [lspr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lspr_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [lspr_pkg::RANGE_W-1:0]    s_range_value,
    input  logic                            s_range_valid,
    input  logic                            s_scan_start,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [lspr_pkg::PIX_W-1:0]      m_pixel_x,
    input  logic [lspr_pkg::PIX_W-1:0]      m_pixel_y,
    input  logic                            m_hit,
    input  logic [lspr_pkg::IDX_W-1:0]      m_beam_index,
    output int                              fail_count,
    output int                              pending,
    output int                              checked,
    output int                              hits
);

    localparam int     IMAGE_SIDE  = 500;
    localparam int     Q_SHIFT     = 38;
    localparam int     TURN_STEPS  = 16;
    localparam longint BEAM_X0     = 64'sd652032874;
    localparam int     REPORT_MAX  = 10;

    typedef struct packed {
        logic [lspr_pkg::PIX_W-1:0] pixel_x;
        logic [lspr_pkg::PIX_W-1:0] pixel_y;
        logic                       hit;
        logic [lspr_pkg::IDX_W-1:0] beam_index;
    } pixel_t;

    // Geometry registers and scan position as the block should hold them.
    logic [15:0] start_angle_q;
    logic [15:0] angle_step_q;
    logic [9:0]  ppm_q;
    logic [8:0]  center_q;
    logic [11:0] next_beam;

    pixel_t expected_pixels[$];
    int     fail_n;
    int     checked_n;
    int     hits_n;

    // atan(2^-i) in 2^32 units per turn
    function automatic longint atan_turn32(input int i);
        case (i)
            0:       return 536870912;
            1:       return 316933406;
            2:       return 167458907;
            3:       return 85004756;
            4:       return 42667331;
            5:       return 21354465;
            6:       return 10680862;
            7:       return 5340245;
            8:       return 2670163;
            9:       return 1335087;
            10:      return 667544;
            11:      return 333772;
            12:      return 166886;
            13:      return 83443;
            14:      return 41722;
            default: return 20861;
        endcase
    endfunction

    // Rotate the unit vector to the beam angle; fold the rear half plane forward first.
    function automatic void beam_trig(input logic [15:0] ang, output longint cos_q30,
                                      output longint sin_q30);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        a = ang;
        flip = 1'b0;
        if (a >= 16384 && a < 49152) begin
            a = a - 32768;
            flip = 1'b1;
        end else if (a >= 49152) begin
            a = a - 65536;
        end
        x = BEAM_X0;
        y = 0;
        z = a * 65536;
        for (int i = 0; i < TURN_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn32(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn32(i);
            end
        end
        cos_q30 = flip ? -x : x;
        sin_q30 = flip ? -y : y;
    endfunction

    // center + range * trig * scale, truncated toward zero
    function automatic longint axis_pixel(input logic [15:0] rng, input longint trig);
        longint mag;
        longint r64;
        longint s64;
        longint acc;
        mag = (trig < 0) ? -trig : trig;
        r64 = rng;
        s64 = ppm_q;
        acc = center_q;
        acc = acc <<< Q_SHIFT;
        acc = (trig < 0) ? acc - r64 * mag * s64 : acc + r64 * mag * s64;
        return (acc >= 0) ? (acc >>> Q_SHIFT) : -((-acc) >>> Q_SHIFT);
    endfunction

    function automatic pixel_t project_sample(input logic [15:0] rng, input logic vld,
                                              input logic [11:0] idx);
        pixel_t      p;
        logic [15:0] ang;
        longint      c;
        longint      s;
        longint      px;
        longint      py;
        ang = start_angle_q + idx * angle_step_q;
        beam_trig(ang, c, s);
        px = axis_pixel(rng, c);
        py = axis_pixel(rng, s);
        p.hit = vld && px >= 0 && px < IMAGE_SIDE && py >= 0 && py < IMAGE_SIDE;
        p.pixel_x = p.hit ? px[8:0] : '0;
        p.pixel_y = p.hit ? py[8:0] : '0;
        p.beam_index = idx;
        return p;
    endfunction

    always @(posedge aclk) begin : watch
        pixel_t           want;
        pixel_t           got;
        logic [11:0]      idx;
        lspr_pkg::reg_idx_t reg_sel;
        if (!aresetn) begin
            start_angle_q = 16'h8000;
            angle_step_q  = 16'd182;
            ppm_q         = 10'd100;
            center_q      = 9'd250;
            next_beam     = '0;
            expected_pixels.delete();
            fail_n    = 0;
            checked_n = 0;
            hits_n    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_sel = lspr_pkg::reg_idx_t'(paddr[lspr_pkg::APB_ADDR_W-1:2]);
                case (reg_sel)
                    lspr_pkg::REG_START_ANGLE: start_angle_q = pwdata[15:0];
                    lspr_pkg::REG_ANGLE_STEP:  angle_step_q  = pwdata[15:0];
                    lspr_pkg::REG_PPM:         ppm_q         = pwdata[9:0];
                    lspr_pkg::REG_CENTER:      center_q      = pwdata[8:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                idx = s_scan_start ? '0 : next_beam;
                expected_pixels = {expected_pixels,
                                   project_sample(s_range_value, s_range_valid, idx)};
                next_beam = idx + 1'b1;
            end
            if (m_valid && m_ready) begin
                got = '{m_pixel_x, m_pixel_y, m_hit, m_beam_index};
                if (expected_pixels.size() == 0) begin
                    if (fail_n < REPORT_MAX)
                        $display("unexpected pixel item: x=%0d y=%0d hit=%0b beam=%0d",
                                 got.pixel_x, got.pixel_y, got.hit, got.beam_index);
                    fail_n++;
                end else begin
                    want = expected_pixels.pop_front();
                    checked_n++;
                    if (want.hit)
                        hits_n++;
                    if (got !== want) begin
                        if (fail_n < REPORT_MAX)
                            $display("pixel mismatch: expected x=%0d y=%0d hit=%0b beam=%0d, %s",
                                     want.pixel_x, want.pixel_y, want.hit, want.beam_index,
                                     $sformatf("got x=%0d y=%0d hit=%0b beam=%0d",
                                               got.pixel_x, got.pixel_y, got.hit,
                                               got.beam_index));
                        fail_n++;
                    end
                end
            end
        end
        fail_count <= fail_n;
        pending    <= expected_pixels.size();
        checked    <= checked_n;
        hits       <= hits_n;
    end

endmodule

// ===== tb/tb_lidar_scan_polar_rasterizer_unit.sv =====
// Testbench top for the lidar rasterizer: clock, reset, register writes, sample stimulus, verdict.
`timescale 1ns / 1ps

module tb_lidar_scan_polar_rasterizer_unit;

    // Clock and reset
    logic aclk = 1'b0;
    logic aresetn;

    always #4 aclk = ~aclk;

    // Register port
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lspr_pkg::APB_ADDR_W-1:0] paddr;
    logic [lspr_pkg::APB_DATA_W-1:0] pwdata;
    logic [lspr_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Sample input channel
    logic                            s_valid;
    logic                            s_ready;
    logic [lspr_pkg::RANGE_W-1:0]    s_range_value;
    logic                            s_range_valid;
    logic                            s_scan_start;

    // Pixel output channel
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [lspr_pkg::PIX_W-1:0]      m_pixel_x;
    logic [lspr_pkg::PIX_W-1:0]      m_pixel_y;
    logic                            m_hit;
    logic [lspr_pkg::IDX_W-1:0]      m_beam_index;

    // Checker feedback
    int fail_count;
    int pending;
    int checked;
    int hits;

    // Stimulus bookkeeping
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          samples_sent;
    int          geometry_count;
    logic [9:0]  cur_ppm;

    // Long output stall: requested by the stimulus, counted down by the receiver
    logic stall_req   = 1'b0;
    logic stall_taken = 1'b0;
    int   stall_left  = 0;

    localparam int LONG_STALL   = 400;
    localparam int GROUP_ITEMS  = 90;
    localparam int TAIL_CYCLES  = 48;

    lidar_scan_polar_rasterizer_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_range_value (s_range_value),
        .s_range_valid (s_range_valid),
        .s_scan_start  (s_scan_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_hit         (m_hit),
        .m_beam_index  (m_beam_index)
    );

    lspr_pixel_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_range_value (s_range_value),
        .s_range_valid (s_range_valid),
        .s_scan_start  (s_scan_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_hit         (m_hit),
        .m_beam_index  (m_beam_index),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .hits          (hits)
    );

    // Receiver: stall at the current idle rate, or hold off for a long
    // stretch once when asked, so the queue fills and s_ready drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_req && !stall_taken) begin
            m_ready     <= 1'b0;
            stall_taken <= 1'b1;
            stall_left  <= LONG_STALL;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // Watchdog: generous bound over the slowest legal run.
    initial begin
        #6_000_000;
        $display("simulation failed");
        $finish;
    end

    // One register write: setup cycle, then access cycle, then an idle cycle
    // so that back-to-back writes never touch psel twice in one step.
    task automatic write_reg(input lspr_pkg::reg_idx_t sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Load the whole geometry; call only with the block idle.
    task automatic write_geometry(input logic [15:0] start, input logic [15:0] step,
                                  input logic [9:0] ppm, input logic [8:0] center);
        write_reg(lspr_pkg::REG_START_ANGLE, {16'd0, start});
        write_reg(lspr_pkg::REG_ANGLE_STEP, {16'd0, step});
        write_reg(lspr_pkg::REG_PPM, {22'd0, ppm});
        write_reg(lspr_pkg::REG_CENTER, {23'd0, center});
        cur_ppm = ppm;
        geometry_count++;
    endtask

    // Pick a random geometry, weighting the extremes.
    task automatic random_geometry();
        logic [15:0] start;
        logic [15:0] step;
        logic [9:0]  ppm;
        logic [8:0]  center;
        start = ($urandom_range(3, 0) == 0) ? ($urandom_range(1, 0) ? 16'h8000 : 16'h7FFF)
                                            : 16'($urandom);
        case ($urandom_range(3, 0))
            0:       step = 16'($urandom);
            1:       step = 16'($urandom_range(800, 0) - 400);
            2:       step = {6'($urandom_range(63, 0)), 10'd0};
            default: begin
                case ($urandom_range(3, 0))
                    0:       step = 16'h8000;
                    1:       step = 16'h7FFF;
                    2:       step = 16'hFFFF;
                    default: step = 16'h0000;
                endcase
            end
        endcase
        case ($urandom_range(9, 0))
            0:       ppm = 10'd0;
            1:       ppm = $urandom_range(1, 0) ? 10'd1 : 10'd1023;
            2, 3:    ppm = 10'($urandom_range(1023, 1));
            default: ppm = 10'($urandom_range(200, 1));
        endcase
        case ($urandom_range(7, 0))
            0:       center = 9'd0;
            1:       center = 9'd511;
            2:       center = $urandom_range(1, 0) ? 9'd499 : 9'd500;
            default: center = 9'($urandom_range(511, 0));
        endcase
        write_geometry(start, step, ppm, center);
    endtask

    // Most ranges land within a few hundred pixels of center; the rest span the field.
    function automatic logic [15:0] pick_range();
        int reach;
        reach = (cur_ppm == 0) ? 65535 : 65536 / cur_ppm;
        if (reach > 65535)
            reach = 65535;
        if ($urandom_range(99, 0) < 70)
            return 16'($urandom_range(reach, 0));
        return 16'($urandom);
    endfunction

    // Offer one sample item; insert a random gap first at the sender's idle rate,
    // then hold valid and payload until the item is accepted.
    task automatic offer_sample(input logic [15:0] rng, input logic vld, input logic first);
        if (tx_idle_pct > 0 && $urandom_range(99, 0) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < tx_idle_pct);
        end
        s_valid       <= 1'b1;
        s_range_value <= rng;
        s_range_valid <= vld;
        s_scan_start  <= first;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // One scan: start marker on the first sample when clean, a rare stray marker
    // later on, and mostly finite readings.
    task automatic run_scan(input int len, input bit clean);
        logic first;
        logic vld;
        for (int k = 0; k < len; k++) begin
            first = (k == 0) ? clean : ($urandom_range(99, 0) < 3);
            vld   = ($urandom_range(99, 0) < 90);
            offer_sample(pick_range(), vld, first);
        end
    endtask

    // Drop valid and wait until every predicted pixel has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int goal;
        // Drive every input to a known value before the first edge.
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_range_value  = '0;
        s_range_valid  = 1'b0;
        s_scan_start   = 1'b0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        samples_sent   = 0;
        geometry_count = 0;
        cur_ppm        = 10'd100;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry: zero range, far and invalid readings, a restart mid-scan.
        offer_sample(16'd0, 1'b1, 1'b1);
        offer_sample(16'hFFFF, 1'b1, 1'b0);
        offer_sample(16'hFFFF, 1'b0, 1'b0);
        offer_sample(16'd640, 1'b0, 1'b0);
        offer_sample(16'd640, 1'b1, 1'b0);
        offer_sample(16'd300, 1'b1, 1'b1);
        offer_sample(16'hAAAA, 1'b1, 1'b0);
        offer_sample(16'h5555, 1'b1, 1'b0);
        drain();

        // Extreme angles and scale, center beyond the image edge.
        write_geometry(16'h7FFF, 16'h8000, 10'd1023, 9'd511);
        offer_sample(16'd0, 1'b1, 1'b1);
        offer_sample(16'd255, 1'b1, 1'b0);
        offer_sample(16'd1000, 1'b1, 1'b0);
        offer_sample(16'hFFFF, 1'b1, 1'b0);
        drain();

        // Zero scale: every finite point collapses onto the center.
        write_geometry(16'h0000, 16'h4000, 10'd0, 9'd0);
        offer_sample(16'hFFFF, 1'b1, 1'b1);
        offer_sample(16'd12345, 1'b1, 1'b0);
        offer_sample(16'd0, 1'b0, 1'b0);
        drain();

        // Quarter-turn beams with sub-pixel reach: sums just below zero still truncate to a hit.
        write_geometry(16'h0000, 16'h4000, 10'd1, 9'd0);
        offer_sample(16'd200, 1'b1, 1'b1);
        offer_sample(16'd200, 1'b1, 1'b0);
        offer_sample(16'd200, 1'b1, 1'b0);
        offer_sample(16'd200, 1'b1, 1'b0);
        offer_sample(16'd256, 1'b1, 1'b0);
        drain();

        // Random scans in three idle regimes, four geometries each.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 68 : 0;
            rx_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 6 : 0;
            for (int grp = 0; grp < 4; grp++) begin
                random_geometry();
                // Hold off the receiver once while the sender keeps pushing.
                if (phase == 0 && grp == 1)
                    stall_req <= 1'b1;
                goal = samples_sent + GROUP_ITEMS;
                while (samples_sent < goal)
                    run_scan($urandom_range(40, 1), $urandom_range(99, 0) < 90);
                drain();
            end
        end

        // Let any stray item surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d samples under %0d geometries, %0d pixels checked, %0d hits",
                 samples_sent, geometry_count, checked, hits);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d failing items", fail_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lspr_pkg.sv
sv/lspr_front.sv
sv/lspr_queue.sv
sv/lspr_back.sv
sv/lidar_scan_polar_rasterizer_unit.sv
tb/lspr_pixel_checker.sv
tb/tb_lidar_scan_polar_rasterizer_unit.sv
